@@ design/sct_pkg.sv @@
// ============================================================================
// sct_pkg: shared definitions for the sine / cosine Taylor series unit
// Holds the fixed-point constants, datapath widths, register indexes and
// the sequencer state type.
// ============================================================================
package sct_pkg;

    // Fixed-point constants. Pi and 2*pi are in Q.32, the degree period in Q16.16.
    localparam logic [33:0] PI_Q32      = 34'd13493037705;
    localparam logic [34:0] TWO_PI_Q32  = 35'd26986075410;
    localparam logic [24:0] DEG360_Q16  = 25'd23592960;
    localparam logic [7:0]  DEG180_DIV  = 8'd180;
    localparam int          DEG_SHIFT   = 16;
    localparam int          SER_FRAC    = 26;
    localparam int          RAD_SHIFT   = 32 - SER_FRAC;

    // Datapath widths.
    localparam int ANGLE_W     = 32;
    localparam int VALUE_W     = 32;
    localparam int WORK_W      = 48;
    localparam int MUL_A_W     = 36;
    localparam int MUL_HALF_W  = 18;
    localparam int MUL_B_W     = 29;
    localparam int PROD_W      = 65;
    localparam int ACC_W       = 42;
    localparam int DEN_W       = 8;
    localparam int DIV_BITS    = 8;
    localparam int DIV_CYCLES  = WORK_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
    localparam int FOLD_J_W    = 4;
    localparam int DFOLD_TOP   = 6;
    localparam int RFOLD_TOP   = 12;

    // Configuration port.
    localparam int              TERM_COUNT_W     = 4;
    localparam int              CFG_DATA_W       = 4;
    localparam int              REG_IDX_W        = 1;
    localparam logic [3:0]      TERM_COUNT_RESET = 4'd10;
    localparam logic            UNIT_MODE_RESET  = 1'b0;
    localparam int              MAX_TERMS_DEF    = 12;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TERM_COUNT = 1'b0,
        REG_UNIT_MODE  = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        FUNC_SINE   = 1'b0,
        FUNC_COSINE = 1'b1
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DCHK,
        S_DFOLD,
        S_DLOAD,
        S_DMUL,
        S_DDIV,
        S_RCHK,
        S_RFOLD,
        S_INIT,
        S_ACC,
        S_TMUL,
        S_TDIV,
        S_ROUND
    } sct_state_t;

endpackage

@@ design/sct_in_if.sv @@
// ============================================================================
// sct_in_if: input word channel of the sine / cosine unit
// Carries valid, ready, the function select and the Q16.16 angle.
// ============================================================================
interface sct_in_if
    import sct_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output func, output angle, input ready);
    modport sink   (input valid, input func, input angle, output ready);
endinterface

@@ design/sct_out_if.sv @@
// ============================================================================
// sct_out_if: output word channel of the sine / cosine unit
// Carries valid, ready and the Q8.24 result value.
// ============================================================================
interface sct_out_if
    import sct_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ design/sine_cosine_taylor_series_unit.sv @@
// ============================================================================
// sine_cosine_taylor_series_unit: fixed-point Taylor series sine / cosine
// Range-reduces a Q16.16 angle and sums alternating series terms with one
// shared multiplier, a small-divisor divider and a fold subtractor.
// ============================================================================
// Flow, accept to result valid, with n terms (n = term count, capped): degree angles
// are folded if above 360 degrees and converted to radians, radian values are folded
// if above 2*pi, then the series runs n terms and the sum is rounded.
// A word is taken only in the idle state, so a new word waits until the last result
// is taken into the output register; each term takes two multiplies and two divides.
// Reset (rst_n low, asynchronous) returns to idle, term_count = 10, radians.
// ============================================================================
module sine_cosine_taylor_series_unit
    import sct_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sct_in_if.sink                din,
    sct_out_if.source             dout,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Term counter and series index widths follow from the term limit.
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int K_W   = $clog2(2 * MAX_TERMS + 2);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    sct_state_t                state_reg, state_next;
    logic [TERM_COUNT_W-1:0]   term_count_reg;
    logic                      unit_mode_reg;

    logic                      cos_reg, cos_next;
    logic                      neg_reg, neg_next;
    // Working value: magnitude, fold remainder and finally the radian value.
    logic [WORK_W-1:0]         val_reg, val_next;
    logic [FOLD_J_W-1:0]       j_reg, j_next;
    logic [MUL_B_W-1:0]        x_reg, x_next;
    logic [MUL_A_W-1:0]        t_reg, t_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic [CNT_W-1:0]          i_reg, i_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic                      step_reg, step_next;
    logic                      phase_reg, phase_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic [MUL_A_W-1:0]        mul_a_reg, mul_a_next;
    logic [MUL_B_W-1:0]        mul_b_reg, mul_b_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;

    logic [WORK_W-1:0]         div_num_reg, div_num_next;
    logic [DEN_W-1:0]          div_rem_reg, div_rem_next;
    logic [DEN_W-1:0]          div_den_reg, div_den_next;
    logic [DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]            angle_u;
    logic [ANGLE_W-1:0]            mag;
    logic                          in_accept;
    logic                          out_free;

    logic [WORK_W-1:0]             chk_mod;
    logic                          chk_gt;
    logic [WORK_W-1:0]             fold_mod;
    logic                          fold_ge;
    logic [WORK_W-1:0]             fold_val;
    logic [WORK_W-1:0]             fold_plus1;
    logic                          fold_last;

    logic [MUL_HALF_W-1:0]         mul_half;
    logic [MUL_HALF_W+MUL_B_W-1:0] mul_out;
    logic [PROD_W-1:0]             mul_sum;

    logic [WORK_W-1:0]             div_q;
    logic [DEN_W-1:0]              div_r;
    logic                          div_last;

    logic [TERM_COUNT_W:0]         tc_ext;
    logic [CNT_W-1:0]              n_cap;
    logic [CNT_W-1:0]              i_inc;
    logic                          term_last;
    logic [K_W-1:0]                k_den;

    logic [ACC_W-1:0]              acc_mag;
    logic [ACC_W-1:0]              acc_rnd;
    logic                          res_neg;
    logic signed [VALUE_W-1:0]     res_sat;

    assign in_accept = din.valid && din.ready;
    assign out_free  = !out_valid_reg || dout.ready;

    // Magnitude of the angle; the most negative angle gives 2^31.
    assign angle_u = din.angle;
    assign mag     = angle_u[ANGLE_W-1] ? (~angle_u + 1'b1) : angle_u;

    // Fold unit: one compare and subtract of a shifted period per cycle,
    // a restoring remainder that leaves the value in (0, period].
    assign chk_mod    = (state_reg == S_DCHK) ? WORK_W'(DEG360_Q16) : WORK_W'(TWO_PI_Q32);
    assign chk_gt     = val_reg > chk_mod;
    assign fold_mod   = ((state_reg == S_DFOLD) ? WORK_W'(DEG360_Q16) : WORK_W'(TWO_PI_Q32))
                        << j_reg;
    assign fold_ge    = val_reg >= fold_mod;
    assign fold_val   = fold_ge ? (val_reg - fold_mod) : val_reg;
    assign fold_plus1 = fold_val + 1'b1;
    assign fold_last  = (j_reg == '0);

    // Multiplier: one 18 x 29 product per cycle, low half first.
    assign mul_half = phase_reg ? mul_a_reg[MUL_A_W-1:MUL_HALF_W]
                                : mul_a_reg[MUL_HALF_W-1:0];
    assign mul_out  = mul_half * mul_b_reg;
    assign mul_sum  = prod_reg + (PROD_W'(mul_out) << MUL_HALF_W);

    // Divider by a small divisor: the remainder stays below the divisor,
    // so eight narrow quotient steps fit in one cycle.
    always_comb
    begin
        logic [WORK_W-1:0] num;
        logic [DEN_W-1:0]  rem;
        logic [DEN_W:0]    trial;
        num = div_num_reg;
        rem = div_rem_reg;
        for (int s = 0; s < DIV_BITS; s++)
        begin
            trial = {rem, num[WORK_W-1]};
            num   = num << 1;
            if (trial >= {1'b0, div_den_reg})
            begin
                trial  = trial - {1'b0, div_den_reg};
                num[0] = 1'b1;
            end
            rem = trial[DEN_W-1:0];
        end
        div_q = num;
        div_r = rem;
    end

    assign div_last = (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));

    // Term bookkeeping.
    assign tc_ext    = {1'b0, term_count_reg};
    assign n_cap     = (tc_ext > (TERM_COUNT_W + 1)'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                                : CNT_W'(tc_ext);
    assign i_inc     = i_reg + 1'b1;
    assign term_last = (i_inc == n_reg);
    assign k_den     = step_reg ? (k_reg + K_W'(2)) : (k_reg + K_W'(1));

    // Output rounding: Q.26 to Q8.24, half away from zero, then sine takes
    // back the input sign, then saturation to 32 bits.
    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign acc_rnd = (acc_mag + ACC_W'(2)) >> 2;
    assign res_neg = acc_reg[ACC_W-1] ^ (!cos_reg && neg_reg);

    always_comb
    begin
        if (res_neg)
        begin
            if (acc_rnd > ACC_W'(64'h8000_0000))
                res_sat = {1'b1, {(VALUE_W-1){1'b0}}};
            else
                res_sat = VALUE_W'(-acc_rnd);
        end
        else
        begin
            if (acc_rnd > ACC_W'(64'h7FFF_FFFF))
                res_sat = {1'b0, {(VALUE_W-1){1'b1}}};
            else
                res_sat = VALUE_W'(acc_rnd);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = unit_mode_reg ? S_DCHK : S_RCHK;
            end
            S_DCHK:
            begin
                state_next = chk_gt ? S_DFOLD : S_DLOAD;
            end
            S_DFOLD:
            begin
                if (fold_last)
                    state_next = S_DLOAD;
            end
            S_DLOAD:
            begin
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                if (phase_reg)
                    state_next = S_DDIV;
            end
            S_DDIV:
            begin
                if (div_last)
                    state_next = S_RCHK;
            end
            S_RCHK:
            begin
                state_next = chk_gt ? S_RFOLD : S_INIT;
            end
            S_RFOLD:
            begin
                if (fold_last)
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                state_next = (n_cap == '0) ? S_ROUND : S_ACC;
            end
            S_ACC:
            begin
                state_next = term_last ? S_ROUND : S_TMUL;
            end
            S_TMUL:
            begin
                if (phase_reg)
                    state_next = S_TDIV;
            end
            S_TDIV:
            begin
                if (div_last)
                    state_next = step_reg ? S_ACC : S_TMUL;
            end
            S_ROUND:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls and register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        cos_next       = cos_reg;
        neg_next       = neg_reg;
        val_next       = val_reg;
        j_next         = j_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        prod_next      = prod_reg;
        div_num_next   = div_q;
        div_rem_next   = div_r;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg + 1'b1;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && !dout.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cos_next = (din.func == FUNC_COSINE);
                    neg_next = angle_u[ANGLE_W-1];
                    if (unit_mode_reg)
                        val_next = WORK_W'(mag);
                    else
                        val_next = WORK_W'(mag) << DEG_SHIFT;
                end
            end
            S_DCHK, S_RCHK:
            begin
                // Fold only values strictly above the period.
                if (chk_gt)
                begin
                    val_next = val_reg - 1'b1;
                    j_next   = (state_reg == S_DCHK) ? FOLD_J_W'(DFOLD_TOP)
                                                     : FOLD_J_W'(RFOLD_TOP);
                end
                else if (state_reg == S_RCHK)
                begin
                    x_next = val_reg[RAD_SHIFT +: MUL_B_W];
                end
            end
            S_DFOLD:
            begin
                val_next = fold_last ? fold_plus1 : fold_val;
                j_next   = j_reg - 1'b1;
            end
            S_DLOAD:
            begin
                mul_a_next = MUL_A_W'(PI_Q32);
                mul_b_next = MUL_B_W'(val_reg);
                phase_next = 1'b0;
            end
            S_DMUL, S_TMUL:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    prod_next = PROD_W'(mul_out);
                end
                else
                begin
                    prod_next    = mul_sum;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    if (state_reg == S_DMUL)
                    begin
                        div_num_next = WORK_W'(mul_sum >> DEG_SHIFT);
                        div_den_next = DEG180_DIV;
                    end
                    else
                    begin
                        div_num_next = WORK_W'(mul_sum >> SER_FRAC);
                        div_den_next = DEN_W'(k_den);
                    end
                end
            end
            S_DDIV:
            begin
                if (div_last)
                    val_next = div_q;
            end
            S_RFOLD:
            begin
                val_next = fold_last ? fold_plus1 : fold_val;
                j_next   = j_reg - 1'b1;
                if (fold_last)
                    x_next = fold_plus1[RAD_SHIFT +: MUL_B_W];
            end
            S_INIT:
            begin
                n_next   = n_cap;
                i_next   = '0;
                acc_next = '0;
                if (cos_reg)
                begin
                    t_next = MUL_A_W'(1) << SER_FRAC;
                    k_next = '0;
                end
                else
                begin
                    t_next = MUL_A_W'(x_reg);
                    k_next = K_W'(1);
                end
            end
            S_ACC:
            begin
                // Even-indexed terms add, odd-indexed terms subtract.
                if (i_reg[0])
                    acc_next = acc_reg - $signed(ACC_W'(t_reg));
                else
                    acc_next = acc_reg + $signed(ACC_W'(t_reg));
                mul_a_next = t_reg;
                mul_b_next = x_reg;
                phase_next = 1'b0;
                step_next  = 1'b0;
            end
            S_TDIV:
            begin
                if (div_last)
                begin
                    t_next     = MUL_A_W'(div_q);
                    mul_a_next = MUL_A_W'(div_q);
                    phase_next = 1'b0;
                    step_next  = !step_reg;
                    if (step_reg)
                    begin
                        k_next = k_reg + K_W'(2);
                        i_next = i_inc;
                    end
                end
            end
            S_ROUND:
            begin
                if (out_free)
                begin
                    out_value_next = res_sat;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Clocked state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            term_count_reg <= TERM_COUNT_RESET;
            unit_mode_reg  <= UNIT_MODE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_TERM_COUNT))
                term_count_reg <= cfg_data[TERM_COUNT_W-1:0];
            if (cfg_we && (cfg_index == REG_UNIT_MODE))
                unit_mode_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg       <= cos_next;
        neg_reg       <= neg_next;
        val_reg       <= val_next;
        j_reg         <= j_next;
        x_reg         <= x_next;
        t_reg         <= t_next;
        k_reg         <= k_next;
        i_reg         <= i_next;
        n_reg         <= n_next;
        step_reg      <= step_next;
        phase_reg     <= phase_next;
        acc_reg       <= acc_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        prod_reg      <= prod_next;
        div_num_reg   <= div_num_next;
        div_rem_reg   <= div_rem_next;
        div_den_reg   <= div_den_next;
        div_cnt_reg   <= div_cnt_next;
        out_value_reg <= out_value_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign din.ready  = (state_reg == S_IDLE);
    assign dout.valid = out_valid_reg;
    assign dout.value = out_value_reg;

endmodule
